[rtl/vsrt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsrt_pkg: shared definitions for the vertex scale/rotate/translate pipeline
// Register map, fixed-point formats and reset values used by every stage.
// ----------------------------------------------------------------------------
package vsrt_pkg;

    localparam int DEF_POS_WIDTH    = 32;
    localparam int DEF_NORMAL_WIDTH = 16;

    // Coefficient formats: scale factors are Q8.8, cosine and sine are Q2.14.
    localparam int COEF_W     = 16;
    localparam int SCALE_FRAC = 8;
    localparam int ROT_FRAC   = 14;

    // Register file geometry.
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int SCALE_W     = 48;
    localparam int TR_W        = 32;
    localparam int ROT_CS_W    = 32;

    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 48'h0100_0100_0100;
    localparam logic [TR_W-1:0]     TR_RESET     = '0;
    localparam logic [ROT_CS_W-1:0] ROT_CS_RESET = 32'h4000_0000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SCALE_XYZ = 3'd0,
        REG_TRANS_X   = 3'd1,
        REG_TRANS_Y   = 3'd2,
        REG_TRANS_Z   = 3'd3,
        REG_ROT_X     = 3'd4,
        REG_ROT_Y     = 3'd5,
        REG_ROT_Z     = 3'd6
    } cfg_reg_t;

endpackage

[rtl/vsrt_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsrt_scale: per-axis position scaling
// Two stages: signed multiply by the Q8.8 factor, then floor shift and
// saturation. The normal is carried alongside unchanged.
// ----------------------------------------------------------------------------
module vsrt_scale
    import vsrt_pkg::*;
#(
    parameter int POS_WIDTH    = DEF_POS_WIDTH,
    parameter int NORMAL_WIDTH = DEF_NORMAL_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [POS_WIDTH-1:0]    in_pos [3],
    input  logic signed [NORMAL_WIDTH-1:0] in_norm [3],
    input  logic [SCALE_W-1:0]             scale_xyz,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [POS_WIDTH-1:0]    out_pos [3],
    output logic signed [NORMAL_WIDTH-1:0] out_norm [3]
);

    localparam int PROD_W = POS_WIDTH + COEF_W;
    localparam int SH_W   = PROD_W - SCALE_FRAC;
    localparam logic signed [SH_W-1:0] SAT_HI =
        {{(SH_W - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
    localparam logic signed [SH_W-1:0] SAT_LO = ~SAT_HI;

    function automatic logic signed [POS_WIDTH-1:0] sat_pos(
        input logic signed [SH_W-1:0] v
    );
        if (v > SAT_HI) begin
            return SAT_HI[POS_WIDTH-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[POS_WIDTH-1:0];
        end else begin
            return v[POS_WIDTH-1:0];
        end
    endfunction

    logic                           va_reg;
    logic                           vb_reg;
    logic                           en_a;
    logic                           en_b;
    logic signed [COEF_W-1:0]       sc [3];
    logic signed [PROD_W-1:0]       prod_reg [3];
    logic signed [NORMAL_WIDTH-1:0] norm_a_reg [3];
    logic signed [POS_WIDTH-1:0]    pos_b_next [3];
    logic signed [POS_WIDTH-1:0]    pos_b_reg [3];
    logic signed [NORMAL_WIDTH-1:0] norm_b_reg [3];

    assign sc[0] = $signed(scale_xyz[3*COEF_W-1:2*COEF_W]);
    assign sc[1] = $signed(scale_xyz[2*COEF_W-1:COEF_W]);
    assign sc[2] = $signed(scale_xyz[COEF_W-1:0]);

    assign en_b     = ~vb_reg | out_ready;
    assign en_a     = ~va_reg | en_b;
    assign in_ready = en_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (en_a) begin
                va_reg <= in_valid;
            end
            if (en_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pos_b_next[k] = sat_pos(prod_reg[k][PROD_W-1:SCALE_FRAC]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            for (int k = 0; k < 3; k++) begin
                prod_reg[k] <= PROD_W'(in_pos[k]) * PROD_W'(sc[k]);
            end
            norm_a_reg <= in_norm;
        end
        if (en_b) begin
            pos_b_reg  <= pos_b_next;
            norm_b_reg <= norm_a_reg;
        end
    end

    assign out_valid = vb_reg;
    assign out_pos   = pos_b_reg;
    assign out_norm  = norm_b_reg;

endmodule

[rtl/vsrt_rotate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsrt_rotate: planar rotation of one coordinate pair
// Computes i' = i*c - j*s and j' = j*c + i*s for the position and the normal,
// passing the third component through. Multiply stage, then sum/shift/sat.
// ----------------------------------------------------------------------------
module vsrt_rotate
    import vsrt_pkg::*;
#(
    parameter int POS_WIDTH    = DEF_POS_WIDTH,
    parameter int NORMAL_WIDTH = DEF_NORMAL_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [POS_WIDTH-1:0]    in_pi,
    input  logic signed [POS_WIDTH-1:0]    in_pj,
    input  logic signed [POS_WIDTH-1:0]    in_pk,
    input  logic signed [NORMAL_WIDTH-1:0] in_ni,
    input  logic signed [NORMAL_WIDTH-1:0] in_nj,
    input  logic signed [NORMAL_WIDTH-1:0] in_nk,
    input  logic [ROT_CS_W-1:0]            cos_sin,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [POS_WIDTH-1:0]    out_pi,
    output logic signed [POS_WIDTH-1:0]    out_pj,
    output logic signed [POS_WIDTH-1:0]    out_pk,
    output logic signed [NORMAL_WIDTH-1:0] out_ni,
    output logic signed [NORMAL_WIDTH-1:0] out_nj,
    output logic signed [NORMAL_WIDTH-1:0] out_nk
);

    localparam int PP_W  = POS_WIDTH + COEF_W;
    localparam int PS_W  = PP_W + 1;
    localparam int PSH_W = PS_W - ROT_FRAC;
    localparam int NP_W  = NORMAL_WIDTH + COEF_W;
    localparam int NS_W  = NP_W + 1;
    localparam int NSH_W = NS_W - ROT_FRAC;

    localparam logic signed [PSH_W-1:0] P_HI =
        {{(PSH_W - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
    localparam logic signed [PSH_W-1:0] P_LO = ~P_HI;
    localparam logic signed [NSH_W-1:0] N_HI =
        {{(NSH_W - NORMAL_WIDTH + 1){1'b0}}, {(NORMAL_WIDTH - 1){1'b1}}};
    localparam logic signed [NSH_W-1:0] N_LO = ~N_HI;

    // The exact sum is floored by dropping the fraction bits of its
    // two's complement form, then clamped to the field range.
    function automatic logic signed [POS_WIDTH-1:0] sat_pos(
        input logic signed [PS_W-1:0] v
    );
        logic signed [PSH_W-1:0] sh;
        sh = $signed(v[PS_W-1:ROT_FRAC]);
        if (sh > P_HI) begin
            return P_HI[POS_WIDTH-1:0];
        end else if (sh < P_LO) begin
            return P_LO[POS_WIDTH-1:0];
        end else begin
            return sh[POS_WIDTH-1:0];
        end
    endfunction

    function automatic logic signed [NORMAL_WIDTH-1:0] sat_norm(
        input logic signed [NS_W-1:0] v
    );
        logic signed [NSH_W-1:0] sh;
        sh = $signed(v[NS_W-1:ROT_FRAC]);
        if (sh > N_HI) begin
            return N_HI[NORMAL_WIDTH-1:0];
        end else if (sh < N_LO) begin
            return N_LO[NORMAL_WIDTH-1:0];
        end else begin
            return sh[NORMAL_WIDTH-1:0];
        end
    endfunction

    logic                           va_reg;
    logic                           vb_reg;
    logic                           en_a;
    logic                           en_b;
    logic signed [COEF_W-1:0]       c;
    logic signed [COEF_W-1:0]       s;

    logic signed [PP_W-1:0]         p_ic_reg, p_js_reg, p_jc_reg, p_is_reg;
    logic signed [NP_W-1:0]         n_ic_reg, n_js_reg, n_jc_reg, n_is_reg;
    logic signed [POS_WIDTH-1:0]    pk_a_reg;
    logic signed [NORMAL_WIDTH-1:0] nk_a_reg;

    logic signed [PS_W-1:0]         p_i_sum, p_j_sum;
    logic signed [NS_W-1:0]         n_i_sum, n_j_sum;

    logic signed [POS_WIDTH-1:0]    pi_next, pj_next;
    logic signed [NORMAL_WIDTH-1:0] ni_next, nj_next;
    logic signed [POS_WIDTH-1:0]    pi_reg, pj_reg, pk_reg;
    logic signed [NORMAL_WIDTH-1:0] ni_reg, nj_reg, nk_reg;

    assign c = $signed(cos_sin[ROT_CS_W-1:COEF_W]);
    assign s = $signed(cos_sin[COEF_W-1:0]);

    assign en_b     = ~vb_reg | out_ready;
    assign en_a     = ~va_reg | en_b;
    assign in_ready = en_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (en_a) begin
                va_reg <= in_valid;
            end
            if (en_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    assign p_i_sum = PS_W'(p_ic_reg) - PS_W'(p_js_reg);
    assign p_j_sum = PS_W'(p_jc_reg) + PS_W'(p_is_reg);
    assign n_i_sum = NS_W'(n_ic_reg) - NS_W'(n_js_reg);
    assign n_j_sum = NS_W'(n_jc_reg) + NS_W'(n_is_reg);

    assign pi_next = sat_pos(p_i_sum);
    assign pj_next = sat_pos(p_j_sum);
    assign ni_next = sat_norm(n_i_sum);
    assign nj_next = sat_norm(n_j_sum);

    always_ff @(posedge aclk) begin
        if (en_a) begin
            p_ic_reg <= PP_W'(in_pi) * PP_W'(c);
            p_js_reg <= PP_W'(in_pj) * PP_W'(s);
            p_jc_reg <= PP_W'(in_pj) * PP_W'(c);
            p_is_reg <= PP_W'(in_pi) * PP_W'(s);
            n_ic_reg <= NP_W'(in_ni) * NP_W'(c);
            n_js_reg <= NP_W'(in_nj) * NP_W'(s);
            n_jc_reg <= NP_W'(in_nj) * NP_W'(c);
            n_is_reg <= NP_W'(in_ni) * NP_W'(s);
            pk_a_reg <= in_pk;
            nk_a_reg <= in_nk;
        end
        if (en_b) begin
            pi_reg <= pi_next;
            pj_reg <= pj_next;
            pk_reg <= pk_a_reg;
            ni_reg <= ni_next;
            nj_reg <= nj_next;
            nk_reg <= nk_a_reg;
        end
    end

    assign out_valid = vb_reg;
    assign out_pi    = pi_reg;
    assign out_pj    = pj_reg;
    assign out_pk    = pk_reg;
    assign out_ni    = ni_reg;
    assign out_nj    = nj_reg;
    assign out_nk    = nk_reg;

endmodule

[rtl/vsrt_translate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsrt_translate: translation and output register
// Adds the Q16.16 offsets to the position with saturation; this stage is
// the block's output register.
// ----------------------------------------------------------------------------
module vsrt_translate
    import vsrt_pkg::*;
#(
    parameter int POS_WIDTH    = DEF_POS_WIDTH,
    parameter int NORMAL_WIDTH = DEF_NORMAL_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [POS_WIDTH-1:0]    in_pos [3],
    input  logic signed [NORMAL_WIDTH-1:0] in_norm [3],
    input  logic signed [TR_W-1:0]         offset [3],
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [POS_WIDTH-1:0]    out_pos [3],
    output logic signed [NORMAL_WIDTH-1:0] out_norm [3]
);

    localparam int SUM_W = ((POS_WIDTH > TR_W) ? POS_WIDTH : TR_W) + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    logic                           vo_reg;
    logic                           en;
    logic signed [SUM_W-1:0]        sum [3];
    logic signed [POS_WIDTH-1:0]    pos_next [3];
    logic signed [POS_WIDTH-1:0]    pos_reg [3];
    logic signed [NORMAL_WIDTH-1:0] norm_reg [3];

    assign en       = ~vo_reg | out_ready;
    assign in_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= in_valid;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k] = SUM_W'(in_pos[k]) + SUM_W'(offset[k]);
            if (sum[k] > SAT_HI) begin
                pos_next[k] = SAT_HI[POS_WIDTH-1:0];
            end else if (sum[k] < SAT_LO) begin
                pos_next[k] = SAT_LO[POS_WIDTH-1:0];
            end else begin
                pos_next[k] = sum[k][POS_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg  <= pos_next;
            norm_reg <= in_norm;
        end
    end

    assign out_valid = vo_reg;
    assign out_pos   = pos_reg;
    assign out_norm  = norm_reg;

endmodule

[rtl/vertex_scale_rotate_translate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_scale_rotate_translate: Euler XYZ vertex transform
// Scales, rotates (X, then Y, then Z) and translates a vertex position and
// rotates its normal, in a fully pipelined datapath.
// ----------------------------------------------------------------------------
// The block accepts one vertex word per clock while s_ready is high and
// returns one transformed word per vertex through nine register stages.
// The stages are two for the scale multiply and clamp, two for each of
// the three rotations (multiply, then sum and clamp) and one for the
// translation, whose register is the output. Every stage holds its own
// valid bit and takes a new word whenever it is empty or its successor
// moves, so bubbles close up and s_ready falls only once all nine stages
// are full behind a stalled output. Configuration registers are read
// live by the datapath and should be written only while no vertex is in
// flight.
module vertex_scale_rotate_translate
    import vsrt_pkg::*;
#(
    parameter int POS_WIDTH    = DEF_POS_WIDTH,
    parameter int NORMAL_WIDTH = DEF_NORMAL_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_we,
    input  logic [CFG_ADDR_W-1:0]          cfg_addr,
    input  logic [CFG_DATA_W-1:0]          cfg_wdata,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [POS_WIDTH-1:0]    s_pos_x,
    input  logic signed [POS_WIDTH-1:0]    s_pos_y,
    input  logic signed [POS_WIDTH-1:0]    s_pos_z,
    input  logic signed [NORMAL_WIDTH-1:0] s_norm_x,
    input  logic signed [NORMAL_WIDTH-1:0] s_norm_y,
    input  logic signed [NORMAL_WIDTH-1:0] s_norm_z,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [POS_WIDTH-1:0]    m_out_pos_x,
    output logic signed [POS_WIDTH-1:0]    m_out_pos_y,
    output logic signed [POS_WIDTH-1:0]    m_out_pos_z,
    output logic signed [NORMAL_WIDTH-1:0] m_out_norm_x,
    output logic signed [NORMAL_WIDTH-1:0] m_out_norm_y,
    output logic signed [NORMAL_WIDTH-1:0] m_out_norm_z
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SCALE_W-1:0]  scale_reg;
    logic [TR_W-1:0]     tr_x_reg, tr_y_reg, tr_z_reg;
    logic [ROT_CS_W-1:0] rot_x_reg, rot_y_reg, rot_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
            tr_x_reg  <= TR_RESET;
            tr_y_reg  <= TR_RESET;
            tr_z_reg  <= TR_RESET;
            rot_x_reg <= ROT_CS_RESET;
            rot_y_reg <= ROT_CS_RESET;
            rot_z_reg <= ROT_CS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_SCALE_XYZ: scale_reg <= cfg_wdata[SCALE_W-1:0];
                REG_TRANS_X:   tr_x_reg  <= cfg_wdata[TR_W-1:0];
                REG_TRANS_Y:   tr_y_reg  <= cfg_wdata[TR_W-1:0];
                REG_TRANS_Z:   tr_z_reg  <= cfg_wdata[TR_W-1:0];
                REG_ROT_X:     rot_x_reg <= cfg_wdata[ROT_CS_W-1:0];
                REG_ROT_Y:     rot_y_reg <= cfg_wdata[ROT_CS_W-1:0];
                REG_ROT_Z:     rot_z_reg <= cfg_wdata[ROT_CS_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic signed [POS_WIDTH-1:0]    in_pos [3];
    logic signed [NORMAL_WIDTH-1:0] in_norm [3];

    logic                           sc_valid, sc_ready;
    logic signed [POS_WIDTH-1:0]    sc_pos [3];
    logic signed [NORMAL_WIDTH-1:0] sc_norm [3];

    logic                           rx_valid, rx_ready;
    logic signed [POS_WIDTH-1:0]    rx_pos [3];
    logic signed [NORMAL_WIDTH-1:0] rx_norm [3];

    logic                           ry_valid, ry_ready;
    logic signed [POS_WIDTH-1:0]    ry_pos [3];
    logic signed [NORMAL_WIDTH-1:0] ry_norm [3];

    logic                           rz_valid, rz_ready;
    logic signed [POS_WIDTH-1:0]    rz_pos [3];
    logic signed [NORMAL_WIDTH-1:0] rz_norm [3];

    logic signed [TR_W-1:0]         offset [3];
    logic signed [POS_WIDTH-1:0]    out_pos [3];
    logic signed [NORMAL_WIDTH-1:0] out_norm [3];

    assign in_pos[0]  = s_pos_x;
    assign in_pos[1]  = s_pos_y;
    assign in_pos[2]  = s_pos_z;
    assign in_norm[0] = s_norm_x;
    assign in_norm[1] = s_norm_y;
    assign in_norm[2] = s_norm_z;

    assign offset[0] = $signed(tr_x_reg);
    assign offset[1] = $signed(tr_y_reg);
    assign offset[2] = $signed(tr_z_reg);

    vsrt_scale #(
        .POS_WIDTH    (POS_WIDTH),
        .NORMAL_WIDTH (NORMAL_WIDTH)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_pos    (in_pos),
        .in_norm   (in_norm),
        .scale_xyz (scale_reg),
        .out_valid (sc_valid),
        .out_ready (sc_ready),
        .out_pos   (sc_pos),
        .out_norm  (sc_norm)
    );

    // About X: the (y, z) pair turns, x passes.
    vsrt_rotate #(
        .POS_WIDTH    (POS_WIDTH),
        .NORMAL_WIDTH (NORMAL_WIDTH)
    ) u_rot_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sc_valid),
        .in_ready  (sc_ready),
        .in_pi     (sc_pos[1]),
        .in_pj     (sc_pos[2]),
        .in_pk     (sc_pos[0]),
        .in_ni     (sc_norm[1]),
        .in_nj     (sc_norm[2]),
        .in_nk     (sc_norm[0]),
        .cos_sin   (rot_x_reg),
        .out_valid (rx_valid),
        .out_ready (rx_ready),
        .out_pi    (rx_pos[1]),
        .out_pj    (rx_pos[2]),
        .out_pk    (rx_pos[0]),
        .out_ni    (rx_norm[1]),
        .out_nj    (rx_norm[2]),
        .out_nk    (rx_norm[0])
    );

    // About Y: the (z, x) pair turns, y passes.
    vsrt_rotate #(
        .POS_WIDTH    (POS_WIDTH),
        .NORMAL_WIDTH (NORMAL_WIDTH)
    ) u_rot_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rx_valid),
        .in_ready  (rx_ready),
        .in_pi     (rx_pos[2]),
        .in_pj     (rx_pos[0]),
        .in_pk     (rx_pos[1]),
        .in_ni     (rx_norm[2]),
        .in_nj     (rx_norm[0]),
        .in_nk     (rx_norm[1]),
        .cos_sin   (rot_y_reg),
        .out_valid (ry_valid),
        .out_ready (ry_ready),
        .out_pi    (ry_pos[2]),
        .out_pj    (ry_pos[0]),
        .out_pk    (ry_pos[1]),
        .out_ni    (ry_norm[2]),
        .out_nj    (ry_norm[0]),
        .out_nk    (ry_norm[1])
    );

    // About Z: the (x, y) pair turns, z passes.
    vsrt_rotate #(
        .POS_WIDTH    (POS_WIDTH),
        .NORMAL_WIDTH (NORMAL_WIDTH)
    ) u_rot_z (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ry_valid),
        .in_ready  (ry_ready),
        .in_pi     (ry_pos[0]),
        .in_pj     (ry_pos[1]),
        .in_pk     (ry_pos[2]),
        .in_ni     (ry_norm[0]),
        .in_nj     (ry_norm[1]),
        .in_nk     (ry_norm[2]),
        .cos_sin   (rot_z_reg),
        .out_valid (rz_valid),
        .out_ready (rz_ready),
        .out_pi    (rz_pos[0]),
        .out_pj    (rz_pos[1]),
        .out_pk    (rz_pos[2]),
        .out_ni    (rz_norm[0]),
        .out_nj    (rz_norm[1]),
        .out_nk    (rz_norm[2])
    );

    vsrt_translate #(
        .POS_WIDTH    (POS_WIDTH),
        .NORMAL_WIDTH (NORMAL_WIDTH)
    ) u_translate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rz_valid),
        .in_ready  (rz_ready),
        .in_pos    (rz_pos),
        .in_norm   (rz_norm),
        .offset    (offset),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_pos   (out_pos),
        .out_norm  (out_norm)
    );

    assign m_out_pos_x  = out_pos[0];
    assign m_out_pos_y  = out_pos[1];
    assign m_out_pos_z  = out_pos[2];
    assign m_out_norm_x = out_norm[0];
    assign m_out_norm_y = out_norm[1];
    assign m_out_norm_z = out_norm[2];

`ifndef NO_ASSERTIONS
    // The input side may only stall when the output itself is held back.
    a_stall_only_from_output: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready)
    ) else $error("input stalled while the output was free");

    // A scaled word held back by the X rotation stays valid and keeps its x position and x normal.
    a_scale_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (sc_valid && !sc_ready) |=> (sc_valid && $stable(sc_pos[0])
                                     && $stable(sc_norm[0]))
    ) else $error("scale stage lost or changed a stalled word");

    // A word held back by the translation stage stays valid and keeps its y position.
    a_rot_z_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (rz_valid && !rz_ready) |=> (rz_valid && $stable(rz_pos[1]))
    ) else $error("Z rotation stage lost or changed a stalled word");

    // Synchronous reset empties the output register.
    a_reset_clears: assert property (
        @(posedge aclk)
        !aresetn |=> !m_valid
    ) else $error("output valid after reset");
`endif

endmodule
